[rtl/bdsr_pkg.sv]
// shared widths, reset values and config types for the boost duty stepper
package bdsr_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int DUTY_W      = 8;
  localparam int CHAN_W      = 2;
  localparam int VOLTS_W     = 7;
  localparam int ROUND_W     = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam int MAX_VOLTS_DEFAULT = 69;

  localparam logic [ROUND_W-1:0] ROUND_RESET = ROUND_W'(200);
  localparam logic [DUTY_W-1:0]  DUTY_MAX    = DUTY_W'(255);
  localparam logic [DUTY_W-1:0]  DUTY_MIN    = DUTY_W'(1);

  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_VOLTS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ROUND_LEN    = CFG_INDEX_W'(1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] target_code;
    logic [ROUND_W-1:0]  round_len;
  } cfg_t;

endpackage

[rtl/bdsr_cfg.sv]
// configuration registers with volts to converter code lookup
module bdsr_cfg #(
  parameter int MAX_VOLTS = bdsr_pkg::MAX_VOLTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bdsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bdsr_pkg::CFG_DATA_W-1:0]    cfg_data,
  output bdsr_pkg::cfg_t                     cfg
);
  import bdsr_pkg::*;

  localparam int TableDepth = 2 ** VOLTS_W;
  localparam int Div        = MAX_VOLTS + 1;
  localparam logic [VOLTS_W:0] MaxVolts = (VOLTS_W + 1)'(MAX_VOLTS);

  logic [SAMPLE_W-1:0] code_table [TableDepth];
  logic [VOLTS_W-1:0]  volts;
  logic                write;

  for (genvar v = 0; v < TableDepth; v++) begin : g_code
    localparam logic [SAMPLE_W-1:0] Code = SAMPLE_W'((v * (2 ** SAMPLE_W)) / Div);
    assign code_table[v] = Code;
  end

  assign cfg_ready = 1'b1;
  assign write     = cfg_valid && cfg_ready;
  assign volts     = cfg_data[VOLTS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_code <= code_table[0];
      cfg.round_len   <= ROUND_RESET;
    end else if (write) begin
      // out-of-range target is dropped
      if (cfg_index == REG_TARGET_VOLTS && {1'b0, volts} <= MaxVolts) begin
        cfg.target_code <= code_table[volts];
      end
      if (cfg_index == REG_ROUND_LEN) begin
        cfg.round_len <= cfg_data[ROUND_W-1:0];
      end
    end
  end

endmodule

[rtl/bdsr_core.sv]
// duty stepper, sensor rotation and result register
module bdsr_core (
  input  logic                            clk,
  input  logic                            rst,
  input  bdsr_pkg::cfg_t                  cfg,
  input  logic                            advance,
  input  logic [bdsr_pkg::SAMPLE_W-1:0]   sample,
  input  logic                            result_stall,
  output logic                            result_valid,
  output logic [bdsr_pkg::DUTY_W-1:0]     boost_duty,
  output logic [bdsr_pkg::CHAN_W-1:0]     next_channel,
  output logic [bdsr_pkg::SAMPLE_W-1:0]   light_level,
  output logic [bdsr_pkg::SAMPLE_W-1:0]   temperature_level
);
  import bdsr_pkg::*;

  typedef enum logic [CHAN_W-1:0] {
    CH_TUBE  = 2'd0,
    CH_LIGHT = 2'd1,
    CH_TEMP  = 2'd2
  } chan_t;

  chan_t               channel, channel_next;
  logic [DUTY_W-1:0]   duty, duty_next;
  logic [ROUND_W-1:0]  count, count_next, count_inc;
  logic [SAMPLE_W-1:0] light, light_next;
  logic [SAMPLE_W-1:0] temp, temp_next;
  logic                round_end;

  assign count_inc = count + ROUND_W'(1);
  assign round_end = count_inc >= cfg.round_len;

  always_comb begin
    channel_next = channel;
    duty_next    = duty;
    count_next   = count;
    light_next   = light;
    temp_next    = temp;
    unique case (channel)
      CH_TUBE: begin
        if (sample > cfg.target_code) begin
          if (duty > DUTY_MIN) duty_next = duty - DUTY_W'(1);
        end else if (sample < cfg.target_code) begin
          if (duty != DUTY_MAX) duty_next = duty + DUTY_W'(1);
        end
        count_next   = round_end ? '0 : count_inc;
        channel_next = round_end ? CH_LIGHT : CH_TUBE;
      end
      CH_LIGHT: begin
        light_next   = sample;
        channel_next = CH_TEMP;
      end
      CH_TEMP: begin
        temp_next    = sample;
        channel_next = CH_TUBE;
      end
      default: channel_next = CH_TUBE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      channel      <= CH_TUBE;
      duty         <= '0;
      count        <= '0;
      light        <= '0;
      temp         <= '0;
    end else begin
      if (advance) begin
        result_valid <= 1'b1;
        channel      <= channel_next;
        duty         <= duty_next;
        count        <= count_next;
        light        <= light_next;
        temp         <= temp_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign boost_duty        = duty;
  assign next_channel      = channel;
  assign light_level       = light;
  assign temperature_level = temp;

endmodule

[rtl/boost_duty_stepper_with_sensor_rotation.sv]
// top level: sample input register, config block and stepper core
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------------
//  sample   | sample_valid / sample_stall | adc_sample
//  result   | result_valid / result_stall | boost_duty, next_channel,
//           |                             | light_level, temperature_level
//  config   | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
//  one beat per cycle while the result is not stalled: a sample is registered in
//  the input register, and an advance then updates the state, which is itself
//  the result register
//  synchronous reset clears the core and held flag; cfg_ready is always high
//  a stalled result holds the state and backs up into sample_stall
module boost_duty_stepper_with_sensor_rotation #(
  parameter int MAX_VOLTS = bdsr_pkg::MAX_VOLTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic [bdsr_pkg::SAMPLE_W-1:0]   adc_sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [bdsr_pkg::DUTY_W-1:0]     boost_duty,
  output logic [bdsr_pkg::CHAN_W-1:0]     next_channel,
  output logic [bdsr_pkg::SAMPLE_W-1:0]   light_level,
  output logic [bdsr_pkg::SAMPLE_W-1:0]   temperature_level,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bdsr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bdsr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bdsr_pkg::*;

  cfg_t                cfg;
  logic                held;
  logic [SAMPLE_W-1:0] held_sample;
  logic                advance;
  logic                accept;

  assign advance      = held && (!result_valid || !result_stall);
  assign sample_stall = held && !advance;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= accept || (held && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_sample <= adc_sample;
    end
  end

  bdsr_cfg #(
    .MAX_VOLTS(MAX_VOLTS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  bdsr_core u_core (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .advance          (advance),
    .sample           (held_sample),
    .result_stall     (result_stall),
    .result_valid     (result_valid),
    .boost_duty       (boost_duty),
    .next_channel     (next_channel),
    .light_level      (light_level),
    .temperature_level(temperature_level)
  );

endmodule

[bench/tb_boost_duty_stepper_with_sensor_rotation.sv]
// testbench: random and directed samples with a self-checking duty and sensor predictor
`timescale 1ns / 1ps

module tb_boost_duty_stepper_with_sensor_rotation;
  import bdsr_pkg::*;

  localparam int MAX_VOLTS = MAX_VOLTS_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int CODE_TOP = (1 << SAMPLE_W) - 1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = CFG_INDEX_W'(3);

  typedef enum logic [CHAN_W-1:0] {CH_TUBE, CH_LIGHT, CH_TEMP, CH_UNUSED} chan_e;
  typedef enum int {MIX_ANY, MIX_BELOW, MIX_ABOVE, MIX_NEAR} mix_e;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] light;
    logic [SAMPLE_W-1:0] temp;
  } result_t;

  class duty_scoreboard;
    logic [DUTY_W-1:0]   duty;
    logic [ROUND_W-1:0]  tube_count;
    chan_e               chan;
    logic [SAMPLE_W-1:0] light;
    logic [SAMPLE_W-1:0] temp;
    logic [SAMPLE_W-1:0] target_code;
    logic [ROUND_W-1:0]  round_len;
    result_t             pending_q[$];
    int                  errors;
    int                  samples;
    int                  results;
    int                  pairs;
    int                  writes;

    function void clear();
      duty = '0;
      tube_count = '0;
      chan = CH_TUBE;
      light = '0;
      temp = '0;
      target_code = '0;
      round_len = ROUND_RESET;
      pending_q.delete();
      errors = 0;
      samples = 0;
      results = 0;
      pairs = 0;
      writes = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      int volts;
      volts = int'(data[VOLTS_W-1:0]);
      writes++;
      if (idx == REG_TARGET_VOLTS) begin
        if (volts <= MAX_VOLTS)
          target_code = SAMPLE_W'((volts << SAMPLE_W) / (MAX_VOLTS + 1));
      end else if (idx == REG_ROUND_LEN) begin
        round_len = data;
      end
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      samples++;
      case (chan)
        CH_TUBE: begin
          if (s > target_code) begin
            if (duty > DUTY_MIN) duty = duty - 1'b1;
          end else if (s < target_code) begin
            if (duty < DUTY_MAX) duty = duty + 1'b1;
          end
          tube_count = tube_count + 1'b1;
          if (tube_count >= round_len) begin
            tube_count = '0;
            chan = CH_LIGHT;
          end
        end
        CH_LIGHT: begin
          light = s;
          chan = CH_TEMP;
        end
        CH_TEMP: begin
          temp = s;
          chan = CH_TUBE;
          pairs++;
        end
        default: chan = CH_TUBE;
      endcase
      pending_q.push_back('{duty: duty, chan: chan, light: light, temp: temp});
    endfunction

    function void check_result(result_t got);
      result_t want;
      results++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected (duty %0d chan %0d)",
                 $time, got.duty, got.chan);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.duty !== want.duty) begin
        $display("%0t: boost_duty expected %0d got %0d", $time, want.duty, got.duty);
        errors++;
      end
      if (got.chan !== want.chan) begin
        $display("%0t: next_channel expected %0d got %0d", $time, want.chan, got.chan);
        errors++;
      end
      if (got.light !== want.light) begin
        $display("%0t: light_level expected %0d got %0d", $time, want.light, got.light);
        errors++;
      end
      if (got.temp !== want.temp) begin
        $display("%0t: temperature_level expected %0d got %0d",
                 $time, want.temp, got.temp);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   sample_valid;
  logic                   sample_stall;
  logic [SAMPLE_W-1:0]    adc_sample;
  logic                   result_valid;
  logic                   result_stall;
  logic [DUTY_W-1:0]      boost_duty;
  logic [CHAN_W-1:0]      next_channel;
  logic [SAMPLE_W-1:0]    light_level;
  logic [SAMPLE_W-1:0]    temperature_level;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  duty_scoreboard sb;
  logic           quiet;
  int             cycles;
  int             duty_lo;
  int             duty_hi;

  boost_duty_stepper_with_sensor_rotation #(.MAX_VOLTS(MAX_VOLTS)) uut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .adc_sample(adc_sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .boost_duty(boost_duty),
    .next_channel(next_channel),
    .light_level(light_level),
    .temperature_level(temperature_level),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, sb.pending_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_result('{duty: boost_duty, chan: next_channel,
                        light: light_level, temp: temperature_level});
      if (int'(boost_duty) < duty_lo) duty_lo = int'(boost_duty);
      if (int'(boost_duty) > duty_hi) duty_hi = int'(boost_duty);
    end
    result_stall <= !quiet && ($urandom_range(99) < 23);
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    if (!quiet && $urandom_range(99) < 23) begin
      sample_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 23) @(posedge clk);
    end
    sample_valid <= 1'b1;
    adc_sample <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sb.note_sample(s);
  endtask

  // drop valid, wait for every expected beat, then let the pipeline go quiet
  task automatic drain_results();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(mix_e mix);
    int t;
    int lo;
    int hi;
    t = int'(sb.target_code);
    lo = 0;
    hi = CODE_TOP;
    case (mix)
      MIX_BELOW: if (t > 0) hi = t - 1;
      MIX_ABOVE: if (t < CODE_TOP) lo = t + 1;
      MIX_NEAR: begin
        lo = (t < 2) ? 0 : t - 2;
        hi = (t > CODE_TOP - 2) ? CODE_TOP : t + 2;
      end
      default: ;
    endcase
    return SAMPLE_W'($urandom_range(hi, lo));
  endfunction

  task automatic run_samples(input int n, input mix_e bias);
    mix_e mix;
    mix = bias;
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) begin
        if (bias == MIX_ANY || $urandom_range(9) >= 8)
          mix = mix_e'($urandom_range(3));
        else
          mix = bias;
      end
      send_sample(pick_sample(mix));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    quiet = 1'b0;
    cycles = 0;
    duty_lo = 1 << DUTY_W;
    duty_hi = -1;
    rst <= 1'b1;
    sample_valid <= 1'b0;
    adc_sample <= '0;
    result_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // duty at zero after reset, target code zero
    send_sample('0);
    send_sample(SAMPLE_W'(CODE_TOP));
    drain_results();

    write_reg(REG_TARGET_VOLTS, CFG_DATA_W'(MAX_VOLTS));
    write_reg(REG_ROUND_LEN, CFG_DATA_W'(10));
    send_sample('0);
    send_sample(SAMPLE_W'(CODE_TOP));
    send_sample(sb.target_code);
    send_sample(sb.target_code - 1'b1);
    send_sample(sb.target_code + 1'b1);
    drain_results();

    // 70, 127 out of range, 8'hC5 is 69; spare indexes do nothing; round shortened
    write_reg(REG_TARGET_VOLTS, CFG_DATA_W'(MAX_VOLTS + 1));
    write_reg(REG_TARGET_VOLTS, CFG_DATA_W'(127));
    write_reg(REG_TARGET_VOLTS, CFG_DATA_W'(8'hC5));
    write_reg(REG_SPARE_2, 8'hFF);
    write_reg(REG_SPARE_3, 8'h00);
    write_reg(REG_ROUND_LEN, CFG_DATA_W'(2));
    send_sample(SAMPLE_W'(500));
    send_sample(SAMPLE_W'(CODE_TOP));
    send_sample('0);
    send_sample('0);
    send_sample('0);
    send_sample('0);
    send_sample(SAMPLE_W'(CODE_TOP));
    drain_results();

    // zero round length: every tube beat is followed by a sensor pair
    write_reg(REG_ROUND_LEN, '0);
    write_reg(REG_TARGET_VOLTS, '0);
    send_sample(SAMPLE_W'(CODE_TOP));
    send_sample(SAMPLE_W'(512));
    send_sample(SAMPLE_W'(513));
    send_sample('0);
    send_sample(SAMPLE_W'(10'h2AA));
    send_sample(SAMPLE_W'(10'h155));
    drain_results();

    // duty climbs to its ceiling with no idling on either side
    quiet = 1'b1;
    write_reg(REG_TARGET_VOLTS, CFG_DATA_W'(MAX_VOLTS));
    write_reg(REG_ROUND_LEN, CFG_DATA_W'(255));
    run_samples(270, MIX_BELOW);
    drain_results();
    quiet = 1'b0;

    // duty falls to its floor
    write_reg(REG_TARGET_VOLTS, CFG_DATA_W'(1));
    write_reg(REG_ROUND_LEN, CFG_DATA_W'(254));
    run_samples(260, MIX_ABOVE);
    drain_results();

    write_reg(REG_TARGET_VOLTS, CFG_DATA_W'(35));
    write_reg(REG_ROUND_LEN, '0);
    run_samples(90, MIX_NEAR);
    drain_results();

    for (int k = 0; k < 4; k++) begin
      write_reg(REG_TARGET_VOLTS, CFG_DATA_W'($urandom_range(127)));
      write_reg(REG_ROUND_LEN, CFG_DATA_W'($urandom_range(20, 1)));
      run_samples(30, MIX_ANY);
      drain_results();
    end

    write_reg(REG_TARGET_VOLTS, CFG_DATA_W'($urandom_range(MAX_VOLTS)));
    write_reg(REG_ROUND_LEN, CFG_DATA_W'(1));
    run_samples(90, MIX_NEAR);
    drain_results();

    $display("run: %0d samples, %0d results checked, %0d register writes, %0d sensor pairs",
             sb.samples, sb.results, sb.writes, sb.pairs);
    $display("boost duty spanned %0d to %0d, %0d mismatches", duty_lo, duty_hi, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
